/* hw/rtl/byte_ring_fifo_pattern_search_unit_defines.svh */
// ----------------------------------------------------------------------------
// Byte ring FIFO pattern search - assertion macros
// Shared property wrappers; they expect clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_PATTERN_SEARCH_UNIT_DEFINES_SVH
`define BYTE_RING_FIFO_PATTERN_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRFPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRFPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/brfps_pkg.sv */
// ----------------------------------------------------------------------------
// Byte ring FIFO pattern search - package
// Operation and status codes, transaction structs and port widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brfps_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_REJECT    = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic {
    CFG_PATTERN     = 1'b0,
    CFG_PATTERN_LEN = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       burst_first;
    logic [7:0] burst_len;
    logic [6:0] read_len;
    logic       direction;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] read_data;
    logic       last;
    logic [7:0] match_index;
    logic [7:0] fill_count;
  } res_t;

endpackage

/* hw/rtl/brfps_obuf.sv */
// ----------------------------------------------------------------------------
// Byte ring FIFO pattern search - result queue
// Two-entry result queue; entry zero drives the master-side stream port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brfps_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  brfps_pkg::res_t push_data,
  output logic            push_ready,
  output logic            out_valid,
  output brfps_pkg::res_t out_data,
  input  logic            out_ready
);

  logic            v0_r, v0_nxt;
  logic            v1_r, v1_nxt;
  brfps_pkg::res_t d0_r, d0_nxt;
  brfps_pkg::res_t d1_r, d1_nxt;
  logic            pop;

  assign pop        = v0_r && out_ready;
  assign push_ready = !v1_r;
  assign out_valid  = v0_r;
  assign out_data   = d0_r;

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    d0_nxt = d0_r;
    d1_nxt = d1_r;
    if (pop) begin
      if (v1_r) begin
        d0_nxt = d1_r;
        v0_nxt = 1'b1;
        v1_nxt = push;
        d1_nxt = push_data;
      end else begin
        d0_nxt = push_data;
        v0_nxt = push;
        v1_nxt = 1'b0;
      end
    end else if (push) begin
      if (!v0_r) begin
        d0_nxt = push_data;
        v0_nxt = 1'b1;
      end else begin
        d1_nxt = push_data;
        v1_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

endmodule

/* hw/rtl/brfps_engine.sv */
// ----------------------------------------------------------------------------
// Byte ring FIFO pattern search - engine
// Byte store, ring pointers and the sequencer for write, read, search, clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_ring_fifo_pattern_search_unit_defines.svh"

module brfps_engine #(
  parameter int DEPTH       = 256,
  parameter int MAX_PATTERN = 8,
  parameter int MAX_READ    = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  brfps_pkg::in_item_t in_item,
  output logic                in_ready,
  input  logic [63:0]         pattern,
  input  logic [3:0]          pat_len,
  output logic                push,
  output brfps_pkg::res_t     res,
  input  logic                push_ready
);

  localparam int AW = $clog2(DEPTH);
  localparam int XW = ((AW > 8) ? AW : 8) + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [3:0]    MAXP_4    = 4'(MAX_PATTERN);
  localparam logic [6:0]    MAXR_7    = 7'(MAX_READ);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  function automatic logic [AW-1:0] p_inc(input logic [AW-1:0] a);
    return (a == LAST_SLOT) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] p_dec(input logic [AW-1:0] a);
    return (a == '0) ? LAST_SLOT : a - AW'(1);
  endfunction

  // Modular a - b on the ring, with b below DEPTH.
  function automatic logic [AW-1:0] p_sub(input logic [AW-1:0] a, input logic [XW-1:0] b);
    logic [XW-1:0] t;
    if (XW'(a) >= b) t = XW'(a) - b;
    else t = XW'(a) + XW'(DEPTH) - b;
    return t[AW-1:0];
  endfunction

  function automatic logic [7:0] to8(input logic [AW-1:0] a);
    logic [XW-1:0] t;
    t = XW'(a);
    return t[7:0];
  endfunction

  // Byte store
  logic [7:0]    mem [DEPTH];
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    rdata_r;

  state_t        st_r, st_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          drop_r, drop_nxt;
  logic [6:0]    rd_left_r, rd_left_nxt;
  logic [AW-1:0] scan_left_r, scan_left_nxt;
  logic [AW-1:0] raddr_r;
  logic [3:0]    seen_r, seen_nxt;
  logic [3:0]    plen_r, plen_nxt;
  logic          dir_r, dir_nxt;
  logic [AW-1:0] match_r, match_nxt;
  logic          found_r, found_nxt;
  logic [MAX_PATTERN-1:0][7:0] sh_r, sh_nxt;

  logic [AW-1:0] fill;
  logic [AW-1:0] freeb;
  logic [3:0]    plen_in;
  logic          wr_ok;
  logic          seen_full;
  logic          win_ok;
  logic          acc;

  assign fill     = p_sub(head_r, XW'(tail_r));
  assign freeb    = LAST_SLOT - fill;
  assign in_ready = (st_r == S_IDLE) && push_ready;
  assign acc      = in_valid && in_ready;
  assign plen_in  = (pat_len == 4'd0) ? 4'd1 : ((pat_len > MAXP_4) ? MAXP_4 : pat_len);

  always_comb begin
    if (in_item.burst_first) wr_ok = (XW'(in_item.burst_len) <= XW'(freeb)) && (freeb != '0);
    else wr_ok = !drop_r && (freeb != '0);
  end

  // Window held in the shift line: entry zero is the byte just read. Scanning
  // upward the window ends there, scanning downward it starts there.
  always_comb begin
    logic [7:0] want;
    sh_nxt[0] = rdata_r;
    for (int i = 1; i < MAX_PATTERN; i++) sh_nxt[i] = sh_r[i-1];
    win_ok = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      want = 8'h00;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if (dir_r) begin
          if (j == i) want = pattern[8*j +: 8];
        end else if ((i + j + 1) == int'(plen_r)) begin
          want = pattern[8*j +: 8];
        end
      end
      if ((i < int'(plen_r)) && (sh_nxt[i] != want)) win_ok = 1'b0;
    end
  end

  assign seen_full = (5'(seen_r) + 5'd1) >= 5'(plen_r);

  always_comb begin
    st_nxt        = st_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    drop_nxt      = drop_r;
    rd_left_nxt   = rd_left_r;
    scan_left_nxt = scan_left_r;
    seen_nxt      = seen_r;
    plen_nxt      = plen_r;
    dir_nxt       = dir_r;
    match_nxt     = match_r;
    found_nxt     = found_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = tail_r;
    push          = 1'b0;
    res           = brfps_pkg::res_t'('0);
    res.last      = 1'b1;

    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_item.op)
            brfps_pkg::OP_WRITE: begin
              if (in_item.burst_first) drop_nxt = (XW'(in_item.burst_len) > XW'(freeb));
              push           = 1'b1;
              res.status     = wr_ok ? brfps_pkg::STAT_OK : brfps_pkg::STAT_REJECT;
              res.fill_count = to8(fill + AW'(wr_ok));
              if (wr_ok) begin
                mem_we   = 1'b1;
                head_nxt = p_inc(head_r);
              end
            end
            brfps_pkg::OP_READ: begin
              if (in_item.read_len == 7'd0) begin
                // Nothing asked for, nothing returned.
              end else if ((in_item.read_len > MAXR_7) ||
                           (XW'(in_item.read_len) > XW'(fill))) begin
                push           = 1'b1;
                res.status     = brfps_pkg::STAT_REJECT;
                res.fill_count = to8(fill);
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = tail_r;
                rd_left_nxt = in_item.read_len;
                st_nxt      = S_READ;
              end
            end
            brfps_pkg::OP_SEARCH: begin
              if (XW'(fill) < XW'(plen_in)) begin
                push           = 1'b1;
                res.status     = brfps_pkg::STAT_NOT_FOUND;
                res.fill_count = to8(fill);
              end else begin
                mem_re        = 1'b1;
                mem_raddr     = in_item.direction ? p_dec(head_r) : tail_r;
                scan_left_nxt = fill - AW'(1);
                seen_nxt      = 4'd0;
                plen_nxt      = plen_in;
                dir_nxt       = in_item.direction;
                st_nxt        = S_SCAN;
              end
            end
            brfps_pkg::OP_CLEAR: begin
              head_nxt       = '0;
              tail_nxt       = '0;
              drop_nxt       = 1'b0;
              push           = 1'b1;
              res.status     = brfps_pkg::STAT_OK;
              res.fill_count = 8'd0;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        // rdata_r holds the byte at tail_r until the queue takes it.
        if (push_ready) begin
          push           = 1'b1;
          res.status     = brfps_pkg::STAT_OK;
          res.read_data  = rdata_r;
          res.last       = (rd_left_r == 7'd1);
          res.fill_count = to8(fill - AW'(1));
          tail_nxt       = p_inc(tail_r);
          rd_left_nxt    = rd_left_r - 7'd1;
          if (rd_left_r == 7'd1) begin
            st_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = p_inc(tail_r);
          end
        end
      end
      S_SCAN: begin
        seen_nxt = seen_full ? plen_r : seen_r + 4'd1;
        if (seen_full && win_ok) begin
          found_nxt = 1'b1;
          match_nxt = dir_r ? raddr_r : p_sub(raddr_r, XW'(plen_r - 4'd1));
          st_nxt    = S_RESP;
        end else if (scan_left_r == '0) begin
          found_nxt = 1'b0;
          st_nxt    = S_RESP;
        end else begin
          mem_re        = 1'b1;
          mem_raddr     = dir_r ? p_dec(raddr_r) : p_inc(raddr_r);
          scan_left_nxt = scan_left_r - AW'(1);
        end
      end
      S_RESP: begin
        if (push_ready) begin
          push            = 1'b1;
          res.status      = found_r ? brfps_pkg::STAT_OK : brfps_pkg::STAT_NOT_FOUND;
          res.match_index = found_r ? to8(match_r) : 8'd0;
          res.fill_count  = to8(fill);
          st_nxt          = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[head_r] <= in_item.data;
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
      raddr_r <= mem_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      head_r <= '0;
      tail_r <= '0;
      drop_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      drop_r <= drop_nxt;
    end
    rd_left_r   <= rd_left_nxt;
    scan_left_r <= scan_left_nxt;
    seen_r      <= seen_nxt;
    plen_r      <= plen_nxt;
    dir_r       <= dir_nxt;
    match_r     <= match_nxt;
    found_r     <= found_nxt;
    if (st_r == S_SCAN) sh_r <= sh_nxt;
  end

  `BRFPS_ASSERT_IMP(a_read_not_empty, st_r == S_READ, fill != '0, "read runs on an empty ring")
  `BRFPS_ASSERT_IMP(a_scan_in_range, st_r == S_SCAN, XW'(scan_left_r) < XW'(fill), "scan overruns stored bytes")
  `BRFPS_ASSERT_NXT(a_clear_empties, acc && (in_item.op == brfps_pkg::OP_CLEAR), (head_r == tail_r) && !drop_r, "clear left data or drop flag")
  `BRFPS_ASSERT_IMP(a_idle_single, push && (st_r == S_IDLE), res.last, "single-result item without last")
  `BRFPS_ASSERT_NXT(a_read_ends, push && (st_r == S_READ) && res.last, st_r == S_IDLE, "read did not return to idle")

endmodule

/* hw/rtl/byte_ring_fifo_pattern_search_unit.sv */
// ----------------------------------------------------------------------------
// Byte ring FIFO pattern search unit - top level
// Holds DEPTH-1 bytes in a ring; pushes, reads, searches and clears on request.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the in_ stream: in_tuser carries the operation, in_tdata
// the operands. Results leave on the out_ stream: out_tuser is the status,
// out_tlast marks the final result of a command. The user is to set the
// pattern and its length through the cfg_ write port only while no command
// is in progress; the block itself does not enforce it. Throughput: a steady
// run of writes goes at one per cycle while the result queue has room; each
// result is registered in the result queue before it leaves on the out_
// stream. A read sends its bytes one per cycle while the queue has room. A
// search scans one stored byte per cycle through the single read port of the
// byte store; a rejected read or a search on too few bytes answers from idle.
// Reset empties the ring, clears the burst drop flag, the result queue and
// the pattern (length one). Results wait in a two-entry queue; when the
// receiver stalls and the queue fills, the engine holds and in_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_ring_fifo_pattern_search_unit #(
  parameter int DEPTH       = 256,
  parameter int MAX_PATTERN = 8,
  parameter int MAX_READ    = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // data[7:0], burst_first[8], burst_len[16:9], read_len[23:17],
  // direction[24], zero fill[31:25]
  input  logic [brfps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_data[7:0], match_index[15:8], fill_count[23:16]
  output logic [brfps_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic                              cfg_idx,
  input  logic [63:0]                       cfg_wdata
);

  logic [63:0]         pattern_r;
  logic [3:0]          pat_len_r;
  brfps_pkg::in_item_t in_item;
  brfps_pkg::res_t     push_data;
  brfps_pkg::res_t     out_data;
  logic                push;
  logic                push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= 64'd0;
      pat_len_r <= 4'd1;
    end else if (cfg_we) begin
      unique case (brfps_pkg::cfg_idx_t'(cfg_idx))
        brfps_pkg::CFG_PATTERN:     pattern_r <= cfg_wdata;
        brfps_pkg::CFG_PATTERN_LEN: pat_len_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.op          = brfps_pkg::op_t'(in_tuser);
    in_item.data        = in_tdata[7:0];
    in_item.burst_first = in_tdata[8];
    in_item.burst_len   = in_tdata[16:9];
    in_item.read_len    = in_tdata[23:17];
    in_item.direction   = in_tdata[24];
  end

  brfps_engine #(
    .DEPTH       (DEPTH),
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_READ    (MAX_READ)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_item    (in_item),
    .in_ready   (in_tready),
    .pattern    (pattern_r),
    .pat_len    (pat_len_r),
    .push       (push),
    .res        (push_data),
    .push_ready (push_ready)
  );

  brfps_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_valid  (out_tvalid),
    .out_data   (out_data),
    .out_ready  (out_tready)
  );

  assign out_tdata = {out_data.fill_count, out_data.match_index, out_data.read_data};
  assign out_tuser = out_data.status;
  assign out_tlast = out_data.last;

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// Byte ring FIFO pattern search unit - testbench
// Sends write, read, search and clear commands over the input stream. The
// random gaps on both streams come and go by phase. The scoreboard below keeps
// its own copy of the ring, the pointers and the pattern registers. It
// predicts every result and compares each received transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import brfps_pkg::*;

localparam int RING_MAX_READ = 64;
localparam int RING_MAX_PAT  = 8;

class fifo_scoreboard;
  bit [7:0]  ring [256];
  bit [7:0]  wr_ptr;
  bit [7:0]  rd_ptr;
  bit        drop_burst;
  bit [63:0] pat;
  bit [3:0]  pat_len = 4'd1;
  res_t      pending [$];
  int        errors;

  function void set_reg(cfg_idx_t idx, bit [63:0] value);
    if (idx == CFG_PATTERN) begin
      pat = value;
    end else begin
      pat_len = value[3:0];
    end
  endfunction

  function bit [7:0] level();
    return wr_ptr - rd_ptr;
  endfunction

  function void push_result(status_t st, bit [7:0] rd, bit lst, bit [7:0] mi,
                            bit [7:0] fc);
    res_t r;
    r.status      = st;
    r.read_data   = rd;
    r.last        = lst;
    r.match_index = mi;
    r.fill_count  = fc;
    pending.push_back(r);
  endfunction

  function bit window_hit(bit [7:0] start, int unsigned plen);
    for (int j = 0; j < plen; j++) begin
      if (ring[8'(start + j)] != pat[8*j +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_input(in_item_t it);
    bit [7:0]    fill_lvl;
    bit [7:0]    room;
    bit          ok;
    bit [7:0]    rd;
    bit [7:0]    start;
    int unsigned plen;
    int unsigned windows;
    int unsigned off;
    fill_lvl = level();
    room     = 8'd255 - fill_lvl;
    start    = 8'd0;
    case (it.op)
      OP_WRITE: begin
        // A first byte decides the fate of its whole burst.
        if (it.burst_first) drop_burst = (it.burst_len > room);
        ok = !drop_burst && room != 8'd0;
        if (ok) begin
          ring[wr_ptr] = it.data;
          wr_ptr++;
          fill_lvl++;
        end
        push_result(ok ? STAT_OK : STAT_REJECT, 8'd0, 1'b1, 8'd0, fill_lvl);
      end
      OP_READ: begin
        if (it.read_len == 7'd0) begin
          // Nothing asked for, nothing returned.
        end else if (it.read_len > RING_MAX_READ || it.read_len > fill_lvl) begin
          push_result(STAT_REJECT, 8'd0, 1'b1, 8'd0, fill_lvl);
        end else begin
          for (int k = 0; k < it.read_len; k++) begin
            rd = ring[rd_ptr];
            rd_ptr++;
            fill_lvl--;
            push_result(STAT_OK, rd, k == it.read_len - 1, 8'd0, fill_lvl);
          end
        end
      end
      OP_SEARCH: begin
        plen = (pat_len == 4'd0) ? 1 : (pat_len > RING_MAX_PAT) ? RING_MAX_PAT : pat_len;
        ok = 1'b0;
        if (fill_lvl >= plen) begin
          windows = fill_lvl - plen + 1;
          for (int k = 0; k < windows && !ok; k++) begin
            off   = it.direction ? windows - 1 - k : k;
            start = 8'(rd_ptr + off);
            ok    = window_hit(start, plen);
          end
        end
        if (ok) begin
          push_result(STAT_OK, 8'd0, 1'b1, start, fill_lvl);
        end else begin
          push_result(STAT_NOT_FOUND, 8'd0, 1'b1, 8'd0, fill_lvl);
        end
      end
      default: begin
        wr_ptr     = 8'd0;
        rd_ptr     = 8'd0;
        drop_burst = 1'b0;
        push_result(STAT_OK, 8'd0, 1'b1, 8'd0, 8'd0);
      end
    endcase
  endfunction

  function void field_check(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      return;
    end
    want = pending.pop_front();
    field_check("status", want.status, got.status);
    field_check("read_data", want.read_data, got.read_data);
    field_check("last", want.last, got.last);
    field_check("match_index", want.match_index, got.match_index);
    field_check("fill_count", want.fill_count, got.fill_count);
  endfunction
endclass

module tb_top;
  import brfps_pkg::*;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic                   cfg_idx    = 1'b0;
  logic [63:0]            cfg_wdata  = '0;

  in_item_t       cmd = '0;
  res_t           seen;
  bit             quiet;
  int unsigned    sent;
  fifo_scoreboard sb;

  assign in_tdata = {7'd0, cmd.direction, cmd.read_len, cmd.burst_len,
                     cmd.burst_first, cmd.data};
  assign in_tuser = cmd.op;

  byte_ring_fifo_pattern_search_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 29);
  end

  // Both streams are watched from one process so that a command is always
  // predicted before any result that it causes is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(cmd);
      if (out_tvalid && out_tready) begin
        seen.status      = status_t'(out_tuser);
        seen.read_data   = out_tdata[7:0];
        seen.last        = out_tlast;
        seen.match_index = out_tdata[15:8];
        seen.fill_count  = out_tdata[23:16];
        sb.check_result(seen);
      end
    end
  end

  function automatic bit [7:0] alpha_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hA5;
      2:       return 8'h5A;
      default: return 8'hFF;
    endcase
  endfunction

  // Mostly a small alphabet, so that searches hit often.
  function automatic bit [7:0] pick_byte();
    return ($urandom_range(3) == 0) ? 8'($urandom) : alpha_byte();
  endfunction

  function automatic bit [63:0] alpha_pattern();
    bit [63:0] p;
    for (int j = 0; j < 8; j++) p[8*j +: 8] = alpha_byte();
    return p;
  endfunction

  // Fields that the operation does not use are left random.
  function automatic in_item_t any_item(op_t op);
    bit [26:0] raw;
    in_item_t  it;
    raw   = 27'($urandom);
    it    = in_item_t'(raw);
    it.op = op;
    return it;
  endfunction

  task automatic send(in_item_t it);
    while (!quiet && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    cmd       <= it;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic push_byte(bit [7:0] value, bit first, bit [7:0] blen);
    in_item_t it;
    it             = any_item(OP_WRITE);
    it.data        = value;
    it.burst_first = first;
    it.burst_len   = blen;
    send(it);
  endtask

  task automatic pull_bytes(bit [6:0] len);
    in_item_t it;
    it          = any_item(OP_READ);
    it.read_len = len;
    send(it);
  endtask

  task automatic find(bit dir);
    in_item_t it;
    it           = any_item(OP_SEARCH);
    it.direction = dir;
    send(it);
  endtask

  task automatic clear_ring();
    send(any_item(OP_CLEAR));
  endtask

  // A burst may open with the current pattern so that long patterns match.
  task automatic write_burst(int unsigned n, bit [7:0] declared, bit seed_pattern);
    bit [7:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      b = (seed_pattern && i < 8) ? sb.pat[8*i +: 8] : pick_byte();
      push_byte(b, i == 0, (i == 0) ? declared : 8'($urandom));
    end
  endtask

  // Holds off new commands until every result is in and the engine is idle.
  // The extra edge lets the monitor note the last accepted command first.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(bit [63:0] pat, bit [3:0] len);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_PATTERN;
    cfg_wdata <= pat;
    @(posedge clk);
    cfg_idx   <= CFG_PATTERN_LEN;
    cfg_wdata <= 64'(len);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(CFG_PATTERN, pat);
    sb.set_reg(CFG_PATTERN_LEN, 64'(len));
  endtask

  task automatic random_sequence();
    int unsigned pick;
    int unsigned n;
    bit [7:0]    lvl;
    pick = $urandom_range(99);
    lvl  = sb.level();
    if (pick < 40) begin
      n = $urandom_range(1, 24);
      write_burst(n, ($urandom_range(4) == 0) ? 8'($urandom) : 8'(n),
                  $urandom_range(3) == 0);
    end else if (pick < 62) begin
      case ($urandom_range(5))
        0:       pull_bytes(7'd0);
        1:       pull_bytes(7'($urandom_range(65, 127)));
        2:       pull_bytes(7'd64);
        default: pull_bytes((lvl == 0) ? 7'd1 :
                            7'($urandom_range(1, (lvl > 64) ? 64 : lvl)));
      endcase
    end else if (pick < 87) begin
      find($urandom_range(1));
    end else if (pick < 91) begin
      clear_ring();
    end else if (pick < 96) begin
      push_byte(pick_byte(), 1'b0, 8'($urandom));
    end else begin
      send(any_item(op_t'($urandom_range(3))));
    end
  endtask

  initial begin
    int unsigned target;
    sb = new;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty ring: over-long read, empty read, search on too few bytes.
    pull_bytes(7'd1);
    pull_bytes(7'd0);
    find(1'b0);
    push_byte(8'h00, 1'b1, 8'd0);
    push_byte(8'hFF, 1'b1, 8'd255);
    push_byte(8'h12, 1'b0, 8'd0);
    clear_ring();
    push_byte(8'hFF, 1'b0, 8'd0);
    push_byte(8'hA5, 1'b1, 8'd3);
    push_byte(8'h5A, 1'b0, 8'd0);
    push_byte(8'h00, 1'b0, 8'd0);
    find(1'b0);
    find(1'b1);
    pull_bytes(7'd127);
    pull_bytes(7'd5);
    pull_bytes(7'd2);
    settle();
    configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    find(1'b0);
    find(1'b1);
    settle();
    configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    write_burst(9, 8'd9, 1'b1);
    find(1'b0);
    find(1'b1);

    // Fill the ring to the brim with no gaps on either stream.
    settle();
    quiet = 1'b1;
    configure(alpha_pattern(), 4'd8);
    clear_ring();
    write_burst(255, 8'd255, 1'b1);
    push_byte(pick_byte(), 1'b0, 8'd0);
    push_byte(pick_byte(), 1'b1, 8'd0);
    find(1'b0);
    find(1'b1);
    pull_bytes(7'd64);
    pull_bytes(7'd64);
    pull_bytes(7'd64);
    pull_bytes(7'd65);
    quiet = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      configure(alpha_pattern(), 4'($urandom_range(0, 15)));
      quiet  = (ph == 2);
      target = sent + 25;
      while (sent < target) random_sequence();
    end
    quiet = 1'b0;

    settle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
